[sv/ws2_pkg.sv]
// Shared types and constants for the WS2812 SPI bit encoder.
`timescale 1ns / 1ps

package ws2_pkg;

  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int LANE_W    = 3 * BYTE_W;
  localparam int LINE_W    = 3 * LANE_W;
  localparam int PEND_W    = WORD_W - 1;
  localparam int PCNT_W    = $clog2(WORD_W);
  localparam int STREAM_W  = PEND_W + LINE_W;
  localparam int MAX_WORDS = 5;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int KIND_W    = 2;

  localparam logic [WORD_W-1:0] ZERO_WORD = 16'h0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
  } stage_t;

endpackage

[sv/ws2_if.sv]
// Handshake interfaces for pixel input and line word output.
`timescale 1ns / 1ps

interface ws2_pix_if
  import ws2_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] blue;

  modport source (output valid, kind, green, red, blue, input ready);
  modport sink   (input valid, kind, green, red, blue, output ready);
endinterface

interface ws2_word_if
  import ws2_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source (output valid, word, last, input ready);
  modport sink   (input valid, word, last, output ready);
endinterface

[sv/ws2812_spi_bit_encoder_top.sv]
// Top level of the WS2812 SPI bit encoder: input stage, three color lanes, word packer.
`timescale 1ns / 1ps

// Takes frame start, pixel and frame end transactions and produces 16-bit
// line words for an SPI serializer, first line bit in bit 15. Each pixel
// data bit becomes 110 (one) or 100 (zero); green, red and blue lanes encode
// in parallel and the packer joins their 72 line bits with up to 8 bits
// held from the previous pixel. The output port delivers one word per
// cycle while out.ready is high; a pixel gives 4 or 5 words, a frame start
// 1 and a frame end 1 or 2; the word queue in the packer sets this rate.
// A transaction's first word passes the input register and then the word
// queue on its way out. An input register takes the next transaction while
// the queue still drains. Kind 3 is consumed without producing words. The
// last flag marks the final word of each input transaction.

module ws2812_spi_bit_encoder_top
  import ws2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ws2_pix_if.sink    pix,
  ws2_word_if.source line
);

  stage_t            stage;
  logic              stage_ready;
  logic [LANE_W-1:0] green_line;
  logic [LANE_W-1:0] red_line;
  logic [LANE_W-1:0] blue_line;

  ws2_lane u_green (.data(pix.green), .line(green_line));
  ws2_lane u_red   (.data(pix.red),   .line(red_line));
  ws2_lane u_blue  (.data(pix.blue),  .line(blue_line));

  assign pix.ready = !stage.valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (pix.ready) begin
      stage.valid <= pix.valid;
    end
    if (pix.ready && pix.valid) begin
      stage.kind <= pix.kind;
      stage.line <= {green_line, red_line, blue_line};
    end
  end

  ws2_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out         (line)
  );

endmodule

[sv/ws2_lane.sv]
// One color lane: expands a data byte into 24 line bits, 110 for one, 100 for zero.
`timescale 1ns / 1ps

module ws2_lane
  import ws2_pkg::*;
(
  input  logic [BYTE_W-1:0] data,
  output logic [LANE_W-1:0] line
);

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      line[3*i+2] = 1'b1;
      line[3*i+1] = data[i];
      line[3*i]   = 1'b0;
    end
  end

endmodule

[sv/ws2_packer.sv]
// Merge stage: joins held bits with lane output and queues the finished words.
`timescale 1ns / 1ps

module ws2_packer
  import ws2_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  output logic         stage_ready,
  ws2_word_if.source   out
);

  logic [PEND_W-1:0]   pend;
  logic [PEND_W-1:0]   pend_next;
  logic [PCNT_W-1:0]   pcnt;
  logic [PCNT_W-1:0]   pcnt_next;
  logic [WORD_W-1:0]   words [MAX_WORDS];
  logic [WORD_W-1:0]   new_words [MAX_WORDS];
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic [STREAM_W-1:0] aligned;
  logic [WORD_W-1:0]   flush_word;
  logic [PCNT_W-1:0]   shamt;
  logic                pop;
  logic                load;

  assign pop         = out.valid && out.ready;
  assign stage_ready = (cnt == '0) || ((cnt == CNT_W'(1)) && out.ready);
  assign load        = stage.valid && stage_ready;
  assign out.valid   = (cnt != '0);
  assign out.word    = words[0];
  assign out.last    = (cnt == CNT_W'(1));

  assign shamt      = PCNT_W'(PEND_W) - pcnt;
  assign aligned    = {pend, stage.line} << shamt;
  assign flush_word = {pend, 1'b0} << shamt;

  always_comb begin
    pend_next = pend;
    pcnt_next = pcnt;
    new_cnt   = '0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      new_words[i] = ZERO_WORD;
    end
    unique case (kind_t'(stage.kind))
      KIND_START: begin
        pend_next = '0;
        pcnt_next = '0;
        new_cnt   = CNT_W'(1);
      end
      KIND_PIXEL: begin
        for (int i = 0; i < MAX_WORDS; i++) begin
          new_words[i] = aligned[STREAM_W-1-WORD_W*i -: WORD_W];
        end
        new_cnt   = pcnt[PCNT_W-1] ? CNT_W'(MAX_WORDS) : CNT_W'(MAX_WORDS - 1);
        pcnt_next = pcnt ^ PCNT_W'(WORD_W / 2);
        pend_next = stage.line[PEND_W-1:0];
      end
      KIND_END: begin
        pend_next = '0;
        pcnt_next = '0;
        if (pcnt != '0) begin
          new_words[0] = flush_word;
          new_cnt      = CNT_W'(2);
        end else begin
          new_cnt = CNT_W'(1);
        end
      end
      default: begin
        new_cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      pcnt <= '0;
      cnt  <= '0;
    end else if (load) begin
      pend <= pend_next;
      pcnt <= pcnt_next;
      cnt  <= new_cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        words[i] <= new_words[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_WORDS - 1; i++) begin
        words[i] <= words[i+1];
      end
      words[MAX_WORDS-1] <= ZERO_WORD;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_WORDS))
    else $error("word queue overfilled");

  a_pixel_words: assert property (@(posedge clk) disable iff (rst)
    load && (stage.kind == KIND_PIXEL) |=>
      (cnt == CNT_W'(MAX_WORDS)) || (cnt == CNT_W'(MAX_WORDS - 1)))
    else $error("pixel did not queue four or five words");

  a_start_word: assert property (@(posedge clk) disable iff (rst)
    load && (stage.kind == KIND_START) |=>
      (cnt == CNT_W'(1)) && (words[0] == ZERO_WORD) && (pcnt == '0))
    else $error("frame start did not queue one zero word");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0) || (pop && (cnt == CNT_W'(1))))
    else $error("queue reloaded while words remain");
`endif

endmodule
